### rtl/core/urde_pkg.sv
// Package for the UART register datagram engine.
// Constants, command type, back-end state type and the CRC-8 helper.
// Depends on nothing; every other file imports it.
package urde_pkg;

    localparam int REG_COUNT = 128;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int FRAME_LEN = 8;
    localparam int FRAME_PW  = $clog2(FRAME_LEN);

    // Frame positions at which a request completes
    localparam logic [FRAME_PW-1:0] READ_DONE_POS  = FRAME_PW'(3);
    localparam logic [FRAME_PW-1:0] WRITE_DONE_POS = FRAME_PW'(FRAME_LEN - 1);

    localparam int WRITE_FLAG_BIT = 7;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] REPLY_SYNC   = 8'h05;
    localparam logic [7:0] REPLY_MASTER = 8'hFF;

    localparam logic [REG_AW-1:0] IFCNT_WORD = REG_AW'(2);
    localparam logic [REG_AW-1:0] PRESET_A_ADDR = REG_AW'(8'h41);
    localparam logic [31:0]       PRESET_A_VAL  = 32'd250;
    localparam logic [REG_AW-1:0] PRESET_B_ADDR = REG_AW'(8'h6F);
    localparam logic [31:0]       PRESET_B_VAL  = 32'h8000_0000;

    // Reply byte indexes
    localparam logic [2:0] RB_SYNC   = 3'd0;
    localparam logic [2:0] RB_MASTER = 3'd1;
    localparam logic [2:0] RB_ADDR   = 3'd2;
    localparam logic [2:0] RB_W3     = 3'd3;
    localparam logic [2:0] RB_W2     = 3'd4;
    localparam logic [2:0] RB_W1     = 3'd5;
    localparam logic [2:0] RB_W0     = 3'd6;
    localparam logic [2:0] RB_CRC    = 3'd7;

    // Configuration register index (byte address bit 2)
    localparam logic CFG_IDX_NODE = 1'b0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        is_write;
        logic [7:0]  addr;
        logic [31:0] word;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SEND
    } back_state_t;

    // One byte into the CRC, least significant bit first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[7] ^ data[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    // Contents of a register file word that has never been written
    function automatic logic [31:0] reg_reset_value(input logic [REG_AW-1:0] addr);
        logic [31:0] val;
        val = 32'd0;
        if (addr == PRESET_A_ADDR)
            val = PRESET_A_VAL;
        else if (addr == PRESET_B_ADDR)
            val = PRESET_B_VAL;
        return val;
    endfunction

endpackage

### rtl/core/urde_front.sv
// Front end: collects request bytes into the frame buffer and classifies them.
// Emits one command per matching complete request. Depends on urde_pkg.
module urde_front
    import urde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic [1:0] node_address,
    output logic       cmd_push,
    output cmd_t       cmd,
    input  logic       cmd_space
);

    logic [7:0]          frame_reg [FRAME_LEN];
    logic [FRAME_PW-1:0] pos_reg;
    logic [FRAME_PW-1:0] pos_next;
    logic                accept;
    logic                is_write;
    logic                match;
    logic                done;

    assign rx_ready = cmd_space;
    assign accept   = rx_valid && rx_ready;

    assign is_write = frame_reg[2][WRITE_FLAG_BIT];
    assign match    = (frame_reg[1] == {6'b0, node_address});
    assign done     = ((pos_reg == WRITE_DONE_POS) && is_write) ||
                      ((pos_reg == READ_DONE_POS) && !is_write);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
            pos_next = done ? '0 : pos_reg + FRAME_PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            frame_reg[pos_reg] <= rx_byte;
    end

    assign cmd_push      = accept && done && match;
    assign cmd.is_write  = is_write;
    assign cmd.addr      = frame_reg[2];
    assign cmd.word      = {frame_reg[3], frame_reg[4], frame_reg[5], frame_reg[6]};

endmodule

### rtl/core/urde_cmd_fifo.sv
// Short command queue between front and back end.
// Two entries; depends on urde_pkg for cmd_t.
module urde_cmd_fifo
    import urde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic has_space,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign has_space = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && has_space;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### rtl/core/urde_back.sv
// Back end: register file, interface counter and read reply generation.
// Pops commands from the queue; depends on urde_pkg.
module urde_back
    import urde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       reply_valid,
    input  logic       reply_ready,
    output logic [7:0] reply_byte,
    output logic       reply_last
);

    back_state_t       state_reg;
    back_state_t       state_next;

    logic [31:0]       mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic [7:0]        addr_reg;
    logic [31:0]       word_reg;
    logic [31:0]       ifcnt_word_reg;
    logic [2:0]        idx_reg;
    logic [7:0]        crc_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic [REG_AW-1:0] cmd_waddr;
    logic              take_write;
    logic              mem_we;
    logic              mem_re;
    logic              load;
    logic [7:0]        sel_byte;

    assign cmd_waddr = cmd.addr[REG_AW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !cmd.is_write)
                    state_next = BK_FETCH;
            end
            BK_FETCH:
                state_next = BK_SEND;
            BK_SEND:
            begin
                if (load && (idx_reg == RB_CRC))
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd_ready  = 1'b0;
        take_write = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready  = 1'b1;
                take_write = cmd_valid && cmd.is_write;
                mem_we     = take_write && (cmd_waddr != IFCNT_WORD);
                mem_re     = cmd_valid && !cmd.is_write;
            end
            BK_FETCH:
                load = 1'b0;
            BK_SEND:
                load = !out_valid_reg || reply_ready;
            default:
                cmd_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Register file: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cmd_waddr] <= cmd.word;
        if (mem_re)
        begin
            rd_data_reg  <= mem[cmd_waddr];
            rd_valid_reg <= valid_reg[cmd_waddr];
            addr_reg     <= cmd.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (mem_we)
            valid_reg[cmd_waddr] <= 1'b1;
    end

    // Interface counter word kept apart from the memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ifcnt_word_reg <= '0;
        else if (take_write)
        begin
            if (cmd_waddr == IFCNT_WORD)
                ifcnt_word_reg <= {cmd.word[31:8], cmd.word[7:0] + 8'd1};
            else
                ifcnt_word_reg[7:0] <= ifcnt_word_reg[7:0] + 8'd1;
        end
    end

    always_comb
    begin
        case (idx_reg)
            RB_SYNC:   sel_byte = REPLY_SYNC;
            RB_MASTER: sel_byte = REPLY_MASTER;
            RB_ADDR:   sel_byte = addr_reg;
            RB_W3:     sel_byte = word_reg[31:24];
            RB_W2:     sel_byte = word_reg[23:16];
            RB_W1:     sel_byte = word_reg[15:8];
            RB_W0:     sel_byte = word_reg[7:0];
            default:   sel_byte = crc_reg;
        endcase
    end

    // Word selection and reply byte sequencing
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_FETCH)
        begin
            if (addr_reg[REG_AW-1:0] == IFCNT_WORD)
                word_reg <= ifcnt_word_reg;
            else if (rd_valid_reg)
                word_reg <= rd_data_reg;
            else
                word_reg <= reg_reset_value(addr_reg[REG_AW-1:0]);
            idx_reg <= RB_SYNC;
            crc_reg <= 8'h00;
        end
        else if (load)
        begin
            idx_reg      <= idx_reg + 3'd1;
            crc_reg      <= crc8_byte(crc_reg, sel_byte);
            out_byte_reg <= sel_byte;
            out_last_reg <= (idx_reg == RB_CRC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (reply_ready)
            out_valid_reg <= 1'b0;
    end

    assign reply_valid = out_valid_reg;
    assign reply_byte  = out_byte_reg;
    assign reply_last  = out_last_reg;

endmodule

### rtl/core/uart_register_datagram_engine.sv
// Top level of the UART register datagram engine.
// Instantiates urde_front, urde_cmd_fifo and urde_back; uses urde_pkg.
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received UART byte per
//   item. A read request completes after four bytes, a write after eight.
//   Only requests whose node byte equals node_address are acted on.
//   reply channel (reply_valid/reply_ready/reply_byte/reply_last) gives the
//   eight bytes of a read reply, reply_last marking the CRC byte.
//   The APB port holds node_address at byte address 0; pready is always high.
// Rate and read path:
//   A byte is taken every cycle while the two-entry command queue has room.
//   A write retires at the edge that pops it. A read passes the queue, the
//   register file read register, the word select register and the output byte
//   register; the back end takes no new command until the reply CRC byte is loaded.
// Reset:
//   Clears framing, queue, back-end state and the register file valid bits;
//   unwritten words read as their power-on values. No clearing pass.
// Stall:
//   When the receiver holds reply_ready low the back end holds its output
//   byte, the queue fills and rx_ready drops once both entries are taken.
module uart_register_datagram_engine
    import urde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        reply_valid,
    input  logic        reply_ready,
    output logic [7:0]  reply_byte,
    output logic        reply_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] node_address_reg;
    logic       cfg_write;

    logic       q_push;
    cmd_t       q_push_cmd;
    logic       q_space;
    logic       q_valid;
    logic       q_ready;
    cmd_t       q_cmd;

    // Configuration port: decode on the register index bit only
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_address_reg <= 2'd0;
        else if (cfg_write && (paddr[2] == CFG_IDX_NODE))
            node_address_reg <= pwdata[1:0];
    end

    // Read back the node address; other addresses read as zero
    assign prdata = (paddr[2] == CFG_IDX_NODE) ? {30'd0, node_address_reg} : 32'd0;

    // Front end: framing and classification
    urde_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .node_address (node_address_reg),
        .cmd_push     (q_push),
        .cmd          (q_push_cmd),
        .cmd_space    (q_space)
    );

    // Queue decouples framing from reply generation
    urde_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .has_space (q_space),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cmd   (q_cmd)
    );

    // Back end: register file and reply sequencer
    urde_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply_byte  (reply_byte),
        .reply_last  (reply_last)
    );

    // A command is only pushed while the queue has room
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> q_space)
        else $error("command pushed into a full queue");

    // Two reply CRC bytes never go out back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid && reply_ready && reply_last) |=> !(reply_valid && reply_last))
        else $error("reply end marker repeated");

    // A write request that completes never produces reply traffic on its own
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_cmd.is_write && !reply_valid) |=> !reply_valid)
        else $error("reply byte produced by a write command");

endmodule
